/* hw/rtl/lmpd_pkg.sv */
// Shared types and constants for the LED matrix pulse driver.
// No dependencies; imported by every module of the block except lmpd_ram.
package lmpd_pkg;

    // Matrix geometry
    localparam int MATRIX_WIDTH  = 18;
    localparam int MATRIX_HEIGHT = 6;
    localparam int LED_TOTAL     = MATRIX_WIDTH * MATRIX_HEIGHT;
    localparam int ADDR_W        = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;

    // Field widths
    localparam int OP_W        = 2;
    localparam int COORD_W     = 6;
    localparam int COLOR_W     = 24;
    localparam int TICK_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int SLOT_PROD_W = 2 * COORD_W + 2;

    // Serial format
    localparam int BITS_PER_LED = 24;
    localparam int BIT_W        = $clog2(BITS_PER_LED);

    // Timing register reset values
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = TICK_W'(14);
    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = TICK_W'(52);
    localparam logic [TICK_W-1:0] LOW_RST       = TICK_W'(52);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_HIGH = 2'd0,
        CFG_ONE_HIGH  = 2'd1,
        CFG_LOW       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] low;
    } t_timing;

    typedef struct packed {
        logic line_level;
        logic busy;
        logic frame_done;
    } t_result;

endpackage

/* hw/rtl/led_matrix_pulse_driver_core.sv */
// A result word is registered in the output register, or in the skid entry while the
// output register holds an untaken one. One input word per cycle while the skid is
// empty; the two-entry output buffer keeps input ready while one result waits. Pixel
// store reads are prefetched. Reset (synchronous, active low) clears sequencer state
// and the store's valid bits at once, so the store reads as zero with no clearing pass.
// Depends on lmpd_pkg, lmpd_engine, lmpd_skid, lmpd_ram.
module led_matrix_pulse_driver_core
    import lmpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [COORD_W-1:0]   i_x_pos,
    input  logic [COORD_W-1:0]   i_y_pos,
    input  logic [COLOR_W-1:0]   i_color,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_line_level,
    output logic                 o_busy_res,
    output logic                 o_frame_done,
    // timing registers
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_data
);

    t_timing r_timing;
    t_result eng_result;
    t_result out_result;
    logic    in_fire;
    logic    eng_sending;

    assign in_fire = i_in_valid && o_in_ready;

    // Timing registers; index three is not decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.zero_high <= ZERO_HIGH_RST;
            r_timing.one_high  <= ONE_HIGH_RST;
            r_timing.low       <= LOW_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ZERO_HIGH: r_timing.zero_high <= i_cfg_data;
                CFG_ONE_HIGH:  r_timing.one_high  <= i_cfg_data;
                CFG_LOW:       r_timing.low       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer and frame store: all state changes at the accepting edge
    lmpd_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (in_fire),
        .i_operation(i_operation),
        .i_x_pos    (i_x_pos),
        .i_y_pos    (i_y_pos),
        .i_color    (i_color),
        .i_timing   (r_timing),
        .o_result   (eng_result),
        .o_sending  (eng_sending)
    );

    // Output register plus skid entry; input ready while the skid is empty
    lmpd_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_fire),
        .i_data     (eng_result),
        .o_ready    (o_in_ready),
        .o_valid    (o_out_valid),
        .o_data     (out_result),
        .i_pop_ready(i_out_ready)
    );

    assign o_line_level = out_result.line_level;
    assign o_busy_res   = out_result.busy;
    assign o_frame_done = out_result.frame_done;

    // Input only stalls when both buffer entries hold results
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    // Frame ends in a low phase of a busy tick
    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (o_busy_res && !o_line_level))
        else $error("frame done reported outside a busy low tick");

    // Sequencer is idle right after reporting frame done
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && eng_result.frame_done) |=> !eng_sending)
        else $error("still sending after frame done");

endmodule

/* hw/rtl/lmpd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lmpd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/lmpd_skid.sv */
// Two-entry output buffer (output register plus skid) for result words.
// Depends on lmpd_pkg.
module lmpd_skid
    import lmpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
                if (i_push) begin
                    r_out <= i_data;
                end
            end
        end else if (i_push) begin
            r_skid       <= i_data;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

/* hw/rtl/lmpd_engine.sv */
// Frame store and pulse sequencer: pixel writes, frame start, tick stepping.
// Depends on lmpd_pkg and lmpd_ram.
module lmpd_engine
    import lmpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [COORD_W-1:0] i_x_pos,
    input  logic [COORD_W-1:0] i_y_pos,
    input  logic [COLOR_W-1:0] i_color,
    input  t_timing            i_timing,
    output t_result            o_result,
    output logic               o_sending
);

    logic                 r_sending, n_sending;
    logic                 r_high, n_high;
    logic [ADDR_W-1:0]    r_led_index, n_led_index;
    logic [BIT_W-1:0]     r_bit_index, n_bit_index;
    logic [TICK_W-1:0]    r_tick_count, n_tick_count;
    logic [COLOR_W-1:0]   r_shift, n_shift;
    logic [ADDR_W-1:0]    r_next_slot, n_next_slot;
    logic [LED_TOTAL-1:0] r_valid;
    logic                 r_fwd_hit;
    logic [COLOR_W-1:0]   r_fwd_data;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_slot;
    logic [COORD_W:0]     wr_row;
    logic [COORD_W:0]     wr_col;
    logic [SLOT_PROD_W-1:0] wr_prod;
    logic                 wr_in_range;
    logic [COLOR_W-1:0]   rd_data;
    logic [COLOR_W-1:0]   next_color;
    logic [TICK_W-1:0]    tick_inc;
    logic [TICK_W-1:0]    high_len;
    logic [ADDR_W:0]      led_plus;
    logic [ADDR_W:0]      n_led_plus;
    logic                 done;
    t_op                  op;

    assign op = t_op'(i_operation);

    // Serpentine mapping: rows counted from the bottom, even rows reversed
    always_comb begin
        wr_in_range = ({1'b0, i_x_pos} < (COORD_W+1)'(MATRIX_WIDTH))
                   && ({1'b0, i_y_pos} < (COORD_W+1)'(MATRIX_HEIGHT));
        wr_row  = (COORD_W+1)'(MATRIX_HEIGHT - 1) - {1'b0, i_y_pos};
        wr_col  = i_y_pos[0] ? {1'b0, i_x_pos}
                             : (COORD_W+1)'(MATRIX_WIDTH - 1) - {1'b0, i_x_pos};
        wr_prod = SLOT_PROD_W'(wr_row) * SLOT_PROD_W'(MATRIX_WIDTH)
                + SLOT_PROD_W'(wr_col);
        wr_slot = wr_prod[ADDR_W-1:0];
        wr_en   = i_fire && (op == OP_WRITE) && wr_in_range;
    end

    // Current content of the slot to be loaded next, including a write that
    // landed on the same edge as the read
    assign next_color = r_fwd_hit ? r_fwd_data
                      : (r_valid[r_next_slot] ? rd_data : '0);

    assign tick_inc = r_tick_count + 1'b1;
    assign high_len = r_shift[COLOR_W-1] ? i_timing.one_high : i_timing.zero_high;
    assign led_plus = {1'b0, r_led_index} + 1'b1;

    always_comb begin
        n_sending    = r_sending;
        n_high       = r_high;
        n_led_index  = r_led_index;
        n_bit_index  = r_bit_index;
        n_tick_count = r_tick_count;
        n_shift      = r_shift;
        done         = 1'b0;
        if (i_fire) begin
            unique case (op)
                OP_START: begin
                    if (!r_sending) begin
                        n_sending    = 1'b1;
                        n_high       = 1'b1;
                        n_led_index  = '0;
                        n_bit_index  = '0;
                        n_tick_count = '0;
                        n_shift      = next_color;
                    end
                end
                OP_TICK: begin
                    if (r_sending) begin
                        n_tick_count = tick_inc;
                        if (r_high) begin
                            if (tick_inc >= high_len) begin
                                n_high       = 1'b0;
                                n_tick_count = '0;
                            end
                        end else if (tick_inc >= i_timing.low) begin
                            n_tick_count = '0;
                            n_high       = 1'b1;
                            n_shift      = {r_shift[COLOR_W-2:0], 1'b0};
                            n_bit_index  = r_bit_index + 1'b1;
                            if (r_bit_index == BIT_W'(BITS_PER_LED - 1)) begin
                                n_bit_index = '0;
                                if (led_plus < (ADDR_W+1)'(LED_TOTAL)) begin
                                    n_led_index = led_plus[ADDR_W-1:0];
                                    n_shift     = next_color;
                                end else begin
                                    n_sending   = 1'b0;
                                    n_high      = 1'b0;
                                    n_led_index = '0;
                                    n_shift     = '0;
                                    done        = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                    // writes go straight to the store; code three does nothing
                end
            endcase
        end
    end

    // Prefetch slot: the LED that follows the current one, slot zero when idle or on the last LED
    always_comb begin
        n_led_plus  = {1'b0, n_led_index} + 1'b1;
        n_next_slot = '0;
        if (n_sending && (n_led_plus < (ADDR_W+1)'(LED_TOTAL))) begin
            n_next_slot = n_led_plus[ADDR_W-1:0];
        end
    end

    // Tick reports the state during the tick, other words the state after
    always_comb begin
        if (op == OP_TICK) begin
            o_result.line_level = r_sending && r_high;
            o_result.busy       = r_sending;
        end else begin
            o_result.line_level = n_sending && n_high;
            o_result.busy       = n_sending;
        end
        o_result.frame_done = done;
    end

    assign o_sending = r_sending;

    lmpd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (LED_TOTAL),
        .ADDR_W(ADDR_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_slot),
        .i_wdata(i_color),
        .i_raddr(n_next_slot),
        .o_rdata(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending    <= 1'b0;
            r_high       <= 1'b0;
            r_led_index  <= '0;
            r_bit_index  <= '0;
            r_tick_count <= '0;
            r_shift      <= '0;
            r_next_slot  <= '0;
            r_valid      <= '0;
            r_fwd_hit    <= 1'b0;
        end else begin
            r_sending    <= n_sending;
            r_high       <= n_high;
            r_led_index  <= n_led_index;
            r_bit_index  <= n_bit_index;
            r_tick_count <= n_tick_count;
            r_shift      <= n_shift;
            r_next_slot  <= n_next_slot;
            r_fwd_hit    <= wr_en && (wr_slot == n_next_slot);
            if (wr_en) begin
                r_valid[wr_slot] <= 1'b1;
            end
        end
        r_fwd_data <= i_color;
    end

endmodule

/* sim/led_matrix_pulse_driver_core_test.sv */
// Self-checking testbench for led_matrix_pulse_driver_core: pixel writes, frame starts, ticks.
// Needs lmpd_pkg and the core RTL. Predicts every result word and checks it field by field.
`timescale 1ns / 1ps

module led_matrix_pulse_driver_core_test;
    import lmpd_pkg::*;

    // Matrix geometry and timing defaults, as the block is specified
    localparam int COLS      = 18;
    localparam int ROWS      = 6;
    localparam int LED_COUNT = COLS * ROWS;
    localparam int LED_BITS  = 24;
    localparam logic [TICK_W-1:0] ZERO_HIGH_INIT = 10'd14;
    localparam logic [TICK_W-1:0] ONE_HIGH_INIT  = 10'd52;
    localparam logic [TICK_W-1:0] LOW_INIT       = 10'd52;
    // Spare opcode: no effect, reports like a write
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_CAP   = 40;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [COLOR_W-1:0] color;
    } t_word;

    // DUT connections; all inputs known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_operation = OP_TICK;
    logic [COORD_W-1:0]   i_x_pos     = '0;
    logic [COORD_W-1:0]   i_y_pos     = '0;
    logic [COLOR_W-1:0]   i_color     = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_line_level;
    logic                 o_busy_res;
    logic                 o_frame_done;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_ZERO_HIGH;
    logic [TICK_W-1:0]    i_cfg_data  = '0;

    led_matrix_pulse_driver_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_color      (i_color),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_line_level (o_line_level),
        .o_busy_res   (o_busy_res),
        .o_frame_done (o_frame_done),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pulse train predictor: own copy of the frame store and sequencer
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] frame_mem [LED_COUNT];
    logic               sending;
    logic               high_phase;
    int                 led_idx;
    int                 bit_idx;
    logic [TICK_W-1:0]  tick_cnt;
    logic [COLOR_W-1:0] shift_reg;
    logic [TICK_W-1:0]  zero_high_len;
    logic [TICK_W-1:0]  one_high_len;
    logic [TICK_W-1:0]  low_len;

    // Serpentine map: rows counted from the bottom, even rows run right to left
    function automatic void store_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                        logic [COLOR_W-1:0] c);
        int col;
        if (x >= COLS || y >= ROWS)
            return;
        col = y[0] ? int'(x) : COLS - 1 - int'(x);
        frame_mem[(ROWS - 1 - int'(y)) * COLS + col] = c;
    endfunction

    function automatic void begin_frame();
        if (sending)
            return;
        sending    = 1'b1;
        high_phase = 1'b1;
        led_idx    = 0;
        bit_idx    = 0;
        tick_cnt   = '0;
        shift_reg  = frame_mem[0];
    endfunction

    // One tick of the time base; returns one when the last bit of the frame ends
    function automatic logic advance_tick();
        logic [TICK_W-1:0] len;
        if (!sending)
            return 1'b0;
        tick_cnt = tick_cnt + 1'b1;
        if (high_phase) begin
            len = shift_reg[COLOR_W-1] ? one_high_len : zero_high_len;
            // a zero length behaves as one tick since elapsed is at least one here
            if (tick_cnt >= len) begin
                high_phase = 1'b0;
                tick_cnt   = '0;
            end
            return 1'b0;
        end
        if (tick_cnt < low_len)
            return 1'b0;
        tick_cnt   = '0;
        high_phase = 1'b1;
        shift_reg  = shift_reg << 1;
        bit_idx++;
        if (bit_idx < LED_BITS)
            return 1'b0;
        bit_idx = 0;
        led_idx++;
        if (led_idx < LED_COUNT) begin
            // next LED latches the store as it is now
            shift_reg = frame_mem[led_idx];
            return 1'b0;
        end
        sending    = 1'b0;
        high_phase = 1'b0;
        led_idx    = 0;
        shift_reg  = '0;
        return 1'b1;
    endfunction

    function automatic t_result pulse_result(t_word w);
        t_result r;
        r.frame_done = 1'b0;
        if (w.op == OP_TICK) begin
            // level and busy describe the tick itself, taken before it advances
            r.line_level = sending && high_phase;
            r.busy       = sending;
            r.frame_done = advance_tick();
        end else begin
            if (w.op == OP_WRITE)
                store_pixel(w.x_pos, w.y_pos, w.color);
            else if (w.op == OP_START)
                begin_frame();
            r.line_level = sending && high_phase;
            r.busy       = sending;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    t_word   pending_words [$];
    t_result expected_levels [$];
    int      words_queued = 0;
    int      results_seen = 0;
    int      err_cnt      = 0;
    int      cycle_cnt    = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      burst_left   = 0;
    logic    in_taken     = 1'b0;

    task automatic report_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Driver: next word goes out at the falling edge once the last one is taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_words
        t_word w;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_words.size() != 0 &&
                (burst_left != 0 || $urandom_range(99) >= send_idle_pct)) begin
                w = pending_words.pop_front();
                i_in_valid  <= 1'b1;
                i_operation <= w.op;
                i_x_pos     <= w.x_pos;
                i_y_pos     <= w.y_pos;
                i_color     <= w.color;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure; occasional bursts with no idling on either side
    always @(negedge i_clk) begin
        if (burst_left != 0)
            burst_left <= burst_left - 1;
        else if ($urandom_range(63) == 0)
            burst_left <= $urandom_range(40, 8);
        i_out_ready <= (burst_left != 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: check result words, then predict for the word taken this edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_words
        t_result want;
        t_word   w;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_levels.pop_front();
                    if (o_line_level !== want.line_level)
                        report_mismatch($sformatf("word %0d line_level %b, want %b",
                                        results_seen, o_line_level, want.line_level));
                    if (o_busy_res !== want.busy)
                        report_mismatch($sformatf("word %0d busy_res %b, want %b",
                                        results_seen, o_busy_res, want.busy));
                    if (o_frame_done !== want.frame_done)
                        report_mismatch($sformatf("word %0d frame_done %b, want %b",
                                        results_seen, o_frame_done, want.frame_done));
                    results_seen++;
                end
            end
            in_taken = i_in_valid && o_in_ready;
            if (in_taken) begin
                w.op    = i_operation;
                w.x_pos = i_x_pos;
                w.y_pos = i_y_pos;
                w.color = i_color;
                expected_levels.push_back(pulse_result(w));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_word(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COLOR_W-1:0] c);
        t_word w;
        w.op    = op;
        w.x_pos = x;
        w.y_pos = y;
        w.color = c;
        pending_words.push_back(w);
        words_queued++;
    endtask

    function automatic t_word random_word(int tick_pct);
        t_word w;
        int    pick;
        w.op    = OP_TICK;
        w.x_pos = COORD_W'($urandom_range(63));
        w.y_pos = COORD_W'($urandom_range(63));
        w.color = COLOR_W'($urandom);
        if ($urandom_range(99) >= tick_pct) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                w.op    = OP_WRITE;
                w.x_pos = COORD_W'($urandom_range(COLS - 1));
                w.y_pos = COORD_W'($urandom_range(ROWS - 1));
            end else if (pick < 78) begin
                w.op = OP_WRITE;   // full coordinate range, mostly off the matrix
            end else if (pick < 92) begin
                w.op = OP_START;
            end else begin
                w.op = OP_SPARE;
            end
        end
        return w;
    endfunction

    // Every pushed word must have come back, plus a margin before returning
    task automatic wait_drained();
        while (results_seen != words_queued)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic set_timing(input logic [TICK_W-1:0] zero_high,
                              input logic [TICK_W-1:0] one_high,
                              input logic [TICK_W-1:0] low);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ZERO_HIGH;
        i_cfg_data  <= zero_high;
        @(negedge i_clk);
        i_cfg_index <= CFG_ONE_HIGH;
        i_cfg_data  <= one_high;
        @(negedge i_clk);
        i_cfg_index <= CFG_LOW;
        i_cfg_data  <= low;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        // nothing is in flight, so the model may take the new values at once
        zero_high_len = zero_high;
        one_high_len  = one_high;
        low_len       = low;
    endtask

    // Registers change only with the block drained; a frame may still be running,
    // which also covers a shortened phase ending on the next tick.
    task automatic run_phase(input logic [TICK_W-1:0] zero_high,
                             input logic [TICK_W-1:0] one_high,
                             input logic [TICK_W-1:0] low,
                             input int idle_pct, input int stall_pct,
                             input int n_words, input int tick_pct);
        t_word w;
        wait_drained();
        set_timing(zero_high, one_high, low);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_words; i++) begin
            w = random_word(tick_pct);
            push_word(w.op, w.x_pos, w.y_pos, w.color);
        end
    endtask

    initial begin
        foreach (frame_mem[i])
            frame_mem[i] = '0;
        sending       = 1'b0;
        high_phase    = 1'b0;
        led_idx       = 0;
        bit_idx       = 0;
        tick_cnt      = '0;
        shift_reg     = '0;
        zero_high_len = ZERO_HIGH_INIT;
        one_high_len  = ONE_HIGH_INIT;
        low_len       = LOW_INIT;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset timing, corners of the matrix, off-matrix writes,
        // spare opcode, start while busy, writes while a frame is going out.
        push_word(OP_TICK,  6'd63, 6'd63, 24'hFFFFFF);   // tick while idle
        push_word(OP_WRITE, 6'd0,  6'd0,  24'hFFFFFF);   // bottom row, reversed
        push_word(OP_WRITE, 6'd17, 6'd5,  24'h000001);   // top row, forward
        push_word(OP_WRITE, 6'd17, 6'd0,  24'h800000);
        push_word(OP_WRITE, 6'd0,  6'd5,  24'h123456);   // first LED sent
        push_word(OP_WRITE, 6'd18, 6'd0,  24'hFFFFFF);   // x just off the edge
        push_word(OP_WRITE, 6'd0,  6'd6,  24'hFFFFFF);   // y just off the edge
        push_word(OP_WRITE, 6'd63, 6'd63, 24'hFFFFFF);
        push_word(OP_WRITE, 6'd63, 6'd0,  24'h000000);
        push_word(OP_SPARE, 6'd1,  6'd1,  24'hABCDEF);
        push_word(OP_START, 6'd0,  6'd0,  24'h000000);
        push_word(OP_START, 6'd63, 6'd63, 24'hFFFFFF);   // ignored, already busy
        push_word(OP_TICK,  6'd0,  6'd0,  24'h000000);
        push_word(OP_TICK,  6'd0,  6'd0,  24'h000000);
        push_word(OP_WRITE, 6'd0,  6'd5,  24'hFFFFFF);   // LED in flight keeps its latch
        push_word(OP_WRITE, 6'd1,  6'd5,  24'hFFFFFF);   // later LED sees the new color
        push_word(OP_SPARE, 6'd63, 6'd63, 24'h000000);
        for (int i = 0; i < 7; i++)
            push_word(OP_TICK, 6'd0, 6'd0, 24'h000000);

        // Random phases over several timing sets, mostly ticks to keep bits moving
        run_phase(10'd1,    10'd1,    10'd1,    0,  0,  400, 92);
        run_phase(10'd1023, 10'd1023, 10'd1023, 63, 0,  150, 60);
        run_phase(10'd0,    10'd0,    10'd0,    0,  63, 350, 92);
        run_phase(10'd3,    10'd9,    10'd2,    17, 17, 150, 85);
        run_phase(10'd1,    10'd1023, 10'd512,  0,  0,  76,  80);

        wait_drained();
        repeat (4) @(negedge i_clk);
        if (expected_levels.size() != 0)
            report_mismatch($sformatf("%0d result words never came",
                            expected_levels.size()));
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
